// ===== rtl/double_ended_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_top_macros
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, masked during rst
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, masked during rst
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// types and codes shared by the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [2:0]         cmd_t;

  localparam cmd_t CMD_DISPLAY    = 3'd0;
  localparam cmd_t CMD_PUSH_FRONT = 3'd1;
  localparam cmd_t CMD_PUSH_BACK  = 3'd2;
  localparam cmd_t CMD_POP_FRONT  = 3'd3;
  localparam cmd_t CMD_POP_BACK   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_t;

  typedef struct packed {
    logic op_take;
    logic start_disp;
    logic rd_issue;
    logic emit_entry;
  } ctrl_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic out_free;
    logic pend;
    logic rd_more;
    logic last_entry;
  } ctrl_sts_t;

endpackage

// ===== rtl/deq_req_if.sv =====
// ----------------------------------------------------------------------------
// deq_req_if
// command channel: one command word per handshake
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  word_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/deq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// deq_rsp_if
// result channel: one result word per handshake
// ----------------------------------------------------------------------------
interface deq_rsp_if import deq_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   entry;
  status_t status;
  logic    last;

  modport source (output valid, output entry, output status, output last, input ready);
  modport sink   (input valid, input entry, input status, input last, output ready);
endinterface

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// controller: accepts commands and sequences the display stream
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  cmd_t      req_cmd,
  output logic      req_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t ctl
);

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctl.start_disp) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (ctl.emit_entry && sts.last_entry) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    accept    = 1'b0;
    ctl       = '0;
    unique case (state)
      S_IDLE: begin
        req_ready      = sts.out_free;
        accept         = req_valid && sts.out_free;
        ctl.start_disp = accept && (req_cmd == CMD_DISPLAY) && !sts.occ_zero;
        ctl.op_take    = accept && !ctl.start_disp;
      end
      S_DISP: begin
        ctl.emit_entry = sts.pend && sts.out_free;
        ctl.rd_issue   = sts.rd_more && (!sts.pend || ctl.emit_entry);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/deq_dp.sv =====
// ----------------------------------------------------------------------------
// deq_dp
// datapath: ring store, front pointer, occupancy and result register
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  word_t     value,
  input  ctrl_cmd_t ctl,
  output ctrl_sts_t sts,
  deq_rsp_if.source rsp
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW:0]   DEPTH_S = (PW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

  logic [PW-1:0] fp, fp_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] rd_cnt, rd_cnt_next;
  logic          pend, pend_next;
  logic          rsp_valid, rsp_valid_next;
  word_t         entry, entry_next;
  status_t       status, status_next;
  logic          last, last_next;

  logic [PW:0]   back_sum, rd_sum;
  logic [PW-1:0] back_addr, rd_addr, fp_dec, fp_inc, waddr;
  logic          full, empty, we, load_op;
  status_t       op_status;
  word_t         rdata;

  // ring arithmetic
  assign back_sum  = {1'b0, fp} + (PW+1)'(occ);
  assign back_addr = (back_sum >= DEPTH_S) ? PW'(back_sum - DEPTH_S) : back_sum[PW-1:0];
  assign rd_sum    = {1'b0, fp} + (PW+1)'(rd_cnt);
  assign rd_addr   = (rd_sum >= DEPTH_S) ? PW'(rd_sum - DEPTH_S) : rd_sum[PW-1:0];
  assign fp_dec    = (fp == '0) ? LAST_P : fp - 1'b1;
  assign fp_inc    = (fp == LAST_P) ? '0 : fp + 1'b1;
  assign full      = (occ == DEPTH_C);
  assign empty     = (occ == '0);

  always_comb begin
    fp_next   = fp;
    occ_next  = occ;
    we        = 1'b0;
    waddr     = back_addr;
    load_op   = 1'b0;
    op_status = ST_OK;
    if (ctl.op_take) begin
      unique case (cmd)
        CMD_DISPLAY: begin
          load_op   = 1'b1;
          op_status = ST_EMPTY;
        end
        CMD_PUSH_FRONT: begin
          load_op = 1'b1;
          if (full) begin
            op_status = ST_FULL;
          end else begin
            we       = 1'b1;
            waddr    = fp_dec;
            fp_next  = fp_dec;
            occ_next = occ + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          load_op = 1'b1;
          if (full) begin
            op_status = ST_FULL;
          end else begin
            we       = 1'b1;
            occ_next = occ + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          load_op = 1'b1;
          if (empty) begin
            op_status = ST_EMPTY;
          end else begin
            fp_next  = fp_inc;
            occ_next = occ - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          load_op = 1'b1;
          if (empty) begin
            op_status = ST_EMPTY;
          end else begin
            occ_next = occ - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // display read sequencing
  always_comb begin
    rd_cnt_next = rd_cnt;
    pend_next   = pend;
    if (ctl.start_disp) begin
      rd_cnt_next = '0;
      pend_next   = 1'b0;
    end else begin
      if (ctl.rd_issue) begin
        rd_cnt_next = rd_cnt + 1'b1;
      end
      if (ctl.rd_issue) begin
        pend_next = 1'b1;
      end else if (ctl.emit_entry) begin
        pend_next = 1'b0;
      end
    end
  end

  // result register
  always_comb begin
    rsp_valid_next = rsp_valid;
    entry_next     = entry;
    status_next    = status;
    last_next      = last;
    priority if (load_op) begin
      rsp_valid_next = 1'b1;
      entry_next     = '0;
      status_next    = op_status;
      last_next      = 1'b1;
    end else if (ctl.emit_entry) begin
      rsp_valid_next = 1'b1;
      entry_next     = rdata;
      status_next    = ST_OK;
      last_next      = (rd_cnt == occ);
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp        <= '0;
      occ       <= '0;
      rd_cnt    <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      fp        <= fp_next;
      occ       <= occ_next;
      rd_cnt    <= rd_cnt_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    entry  <= entry_next;
    status <= status_next;
    last   <= last_next;
  end

  deq_ram #(
    .WIDTH ($bits(word_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value),
    .re    (ctl.rd_issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign sts.occ_zero   = empty;
  assign sts.out_free   = !rsp_valid || rsp.ready;
  assign sts.pend       = pend;
  assign sts.rd_more    = (rd_cnt < occ);
  assign sts.last_entry = (rd_cnt == occ);

  assign rsp.valid  = rsp_valid;
  assign rsp.entry  = entry;
  assign rsp.status = status;
  assign rsp.last   = last;

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_top
// bounded double-ended queue of signed 32-bit words in a ring store
// ----------------------------------------------------------------------------
// channels: req carries one command word (cmd, value); rsp carries result
//   words (entry, status, last), both valid/ready
// push and pop: one result word, registered on the accept edge, so it shows
//   in the cycle after acceptance; a new command is taken every cycle while
//   the result register drains
// display: one result word per entry, front to back, last marks the final
//   one; entries come from the registered ram read, one per cycle unless
//   stalled; no command is taken until the final entry is registered
// display of an empty queue, pop of an empty queue and push to a full
//   queue give a single result word with the matching status
// reset: rst (synchronous) empties the queue and drops any pending result;
//   store contents are left as they are
// stall: while rsp is held off the result register keeps its word and req
//   ready stays low once that register is occupied
// ----------------------------------------------------------------------------
module double_ended_queue_top import deq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (req.cmd),
    .value (req.value),
    .ctl   (ctl),
    .sts   (sts),
    .rsp   (rsp)
  );

endmodule

// ===== rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks on the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
`include "double_ended_queue_top_macros.svh"

module deq_checker import deq_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    req_valid,
  input logic    req_ready,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input word_t   rsp_entry,
  input status_t rsp_status,
  input logic    rsp_last
);

  `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")
  `DEQ_ASSERT_NOW(a_err_single, rsp_valid && (rsp_status != ST_OK), rsp_last && (rsp_entry == '0), "status result not single")
  `DEQ_ASSERT_NOW(a_accept_room, req_valid && req_ready, !rsp_valid || rsp_ready, "command taken with result register blocked")
  `DEQ_ASSERT_NOW(a_reset_clear, $past(rst), !rsp_valid, "result valid straight after reset")

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_entry  (rsp.entry),
  .rsp_status (rsp.status),
  .rsp_last   (rsp.last)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the double-ended queue
// ----------------------------------------------------------------------------
// commands are queued up front and driven with random gaps; every accepted
// command updates a local deque model that queues the result words it should
// give, and the monitor checks each result word against the oldest one.
// the stimulus walks the empty and full corners, runs a gap-free burst while
// the result side is held off, and mixes random commands otherwise
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int   DEPTH       = 64;
  localparam int   LONG_HOLD   = 160;
  localparam int   STALL_LIMIT = 2000;
  localparam int   TAIL_CYCLES = 40;
  localparam int   NUM_ITEMS   = 270;
  localparam cmd_t CMD_UNUSED_LO  = 3'd5;
  localparam cmd_t CMD_UNUSED_MID = 3'd6;
  localparam cmd_t CMD_UNUSED_HI  = 3'd7;

  typedef struct {
    cmd_t        cmd;
    word_t       value;
    int unsigned gap;
    bit          wait_drain;
  } cmd_word_t;

  typedef struct {
    word_t   entry;
    status_t status;
    logic    last;
  } result_word_t;

  logic clk;
  logic rst;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue_top #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  cmd_word_t    cmd_backlog[$];
  result_word_t awaited_results[$];

  word_t       mdl_ring [DEPTH];
  logic [5:0]  mdl_front;
  logic [6:0]  mdl_count;

  int          gen_occ;
  int          hold_at;
  int          sent_cnt;
  int unsigned gap_cnt;
  int          hold_left;
  bit          hold_done;
  int unsigned rx_wait;
  int          results_seen;
  int          idle_cycles;
  int          fail_cnt;

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_DISPLAY;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
  end

  always #6 clk = ~clk;

  task automatic predict_deque_results(input cmd_t c, input word_t v);
    result_word_t r;
    int i;
    r.entry  = '0;
    r.status = ST_OK;
    r.last   = 1'b1;
    case (c)
      CMD_DISPLAY: begin
        if (mdl_count == 0) begin
          r.status = ST_EMPTY;
          awaited_results.push_back(r);
        end else begin
          for (i = 0; i < int'(mdl_count); i++) begin
            r.entry = mdl_ring[mdl_front + 6'(i)];
            r.last  = (i == int'(mdl_count) - 1);
            awaited_results.push_back(r);
          end
        end
      end
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (mdl_count == 7'(DEPTH)) begin
          r.status = ST_FULL;
        end else if (c == CMD_PUSH_FRONT) begin
          mdl_front           = mdl_front - 6'd1;
          mdl_ring[mdl_front] = v;
          mdl_count           = mdl_count + 7'd1;
        end else begin
          mdl_ring[mdl_front + mdl_count[5:0]] = v;
          mdl_count                            = mdl_count + 7'd1;
        end
        awaited_results.push_back(r);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (mdl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c == CMD_POP_FRONT) mdl_front = mdl_front + 6'd1;
          mdl_count = mdl_count - 7'd1;
        end
        awaited_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned sender_gap();
    if ((cmd_backlog.size() / 40) % 3 == 1) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic add_cmd(input cmd_t c, input word_t v, input int unsigned gap,
                         input bit wait_drain);
    cmd_word_t w;
    w.cmd        = c;
    w.value      = v;
    w.gap        = gap;
    w.wait_drain = wait_drain;
    cmd_backlog.push_back(w);
    if ((c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK) && gen_occ < DEPTH) gen_occ++;
    if ((c == CMD_POP_FRONT || c == CMD_POP_BACK) && gen_occ > 0) gen_occ--;
  endtask

  task automatic add_random_cmd(input int unsigned gap, input bit wait_drain);
    int   r;
    cmd_t c;
    r = $urandom_range(0, 19);
    if (r < 4)       c = CMD_PUSH_FRONT;
    else if (r < 8)  c = CMD_PUSH_BACK;
    else if (r < 11) c = CMD_POP_FRONT;
    else if (r < 14) c = CMD_POP_BACK;
    else if (r < 18) c = CMD_DISPLAY;
    else             c = cmd_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    add_cmd(c, rand_word(), gap, wait_drain);
  endtask

  // stimulus and end of run
  initial begin
    int n;
    gen_occ = 0;

    add_cmd(CMD_DISPLAY,    '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_FRONT,  '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_BACK,   '0,           sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_BACK,  32'h7fff_ffff, sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_FRONT, 32'h8000_0000, sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_BACK,  '0,           sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_FRONT, '1,           sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_BACK,  32'h0000_0001, sender_gap(), 1'b0);
    add_cmd(CMD_DISPLAY,    '0,           sender_gap(), 1'b0);
    add_cmd(CMD_UNUSED_LO,  '1,           sender_gap(), 1'b0);
    add_cmd(CMD_UNUSED_MID, '0,           sender_gap(), 1'b0);
    add_cmd(CMD_UNUSED_HI,  32'ha5a5_a5a5, sender_gap(), 1'b0);
    add_cmd(CMD_POP_FRONT,  '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_BACK,   '0,           sender_gap(), 1'b0);
    add_cmd(CMD_DISPLAY,    '0,           sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_FRONT, 32'h5555_5555, sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_BACK,  32'haaaa_aaaa, sender_gap(), 1'b0);
    add_cmd(CMD_DISPLAY,    '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_BACK,   '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_FRONT,  '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_BACK,   '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_FRONT,  '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_FRONT,  '0,           sender_gap(), 1'b0);
    add_cmd(CMD_POP_BACK,   '0,           sender_gap(), 1'b0);
    add_cmd(CMD_DISPLAY,    '0,           sender_gap(), 1'b0);

    // sender waits for every result word before going on
    add_cmd(CMD_PUSH_BACK, rand_word(), sender_gap(), 1'b1);

    // gap-free burst while the result side is held off
    hold_at = cmd_backlog.size();
    for (n = 0; n < 24; n++) add_random_cmd(0, 1'b0);

    // fill to full, overflow, display, then empty and underflow
    while (gen_occ < DEPTH)
      add_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rand_word(),
              sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_FRONT, rand_word(), sender_gap(), 1'b0);
    add_cmd(CMD_PUSH_BACK,  rand_word(), sender_gap(), 1'b0);
    add_cmd(CMD_DISPLAY,    rand_word(), sender_gap(), 1'b1);
    add_cmd(cmd_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), rand_word(),
            sender_gap(), 1'b0);
    while (gen_occ > 0)
      add_cmd($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, rand_word(),
              sender_gap(), 1'b0);
    add_cmd(CMD_POP_FRONT, rand_word(), sender_gap(), 1'b0);
    add_cmd(CMD_POP_BACK,  rand_word(), sender_gap(), 1'b0);
    add_cmd(CMD_DISPLAY,   rand_word(), sender_gap(), 1'b0);

    while (cmd_backlog.size() < NUM_ITEMS)
      add_random_cmd(sender_gap(), $urandom_range(0, 29) == 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || req_ch.valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // command driver
  always @(posedge clk) begin
    cmd_word_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_cnt      <= 0;
      sent_cnt     <= 0;
      mdl_front     = '0;
      mdl_count     = '0;
      awaited_results.delete();
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_deque_results(req_ch.cmd, req_ch.value);
        sent_cnt <= sent_cnt + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (cmd_backlog.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if (gap_cnt < cmd_backlog[0].gap ||
                     (cmd_backlog[0].wait_drain && awaited_results.size() != 0)) begin
          req_ch.valid <= 1'b0;
          gap_cnt      <= gap_cnt + 1;
        end else begin
          nxt           = cmd_backlog.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd   <= nxt.cmd;
          req_ch.value <= nxt.value;
          gap_cnt      <= 0;
        end
      end
    end
  end

  // long hold-off of the result side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= hold_at) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_word_t exp_w;
    int unsigned  w;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_wait      <= 0;
      results_seen  = 0;
    end else begin
      w = rx_wait;
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result word with nothing awaited: entry %0d status %0d last %0b",
                 rsp_ch.entry, rsp_ch.status, rsp_ch.last);
          fail_cnt++;
        end else begin
          exp_w = awaited_results.pop_front();
          if (rsp_ch.entry !== exp_w.entry) begin
            $error("entry: expected %0d, got %0d", exp_w.entry, rsp_ch.entry);
            fail_cnt++;
          end
          if (rsp_ch.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, rsp_ch.status);
            fail_cnt++;
          end
          if (rsp_ch.last !== exp_w.last) begin
            $error("last: expected %0b, got %0b", exp_w.last, rsp_ch.last);
            fail_cnt++;
          end
        end
        w = (results_seen % 80 < 25) ? 0 : $urandom_range(0, 19);
      end else if (w != 0) begin
        w = w - 1;
      end
      rx_wait      <= w;
      rsp_ch.ready <= (w == 0) && (hold_left == 0);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no handshake for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial fail_cnt = 0;

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_req_if.sv
rtl/deq_rsp_if.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue_top.sv
rtl/deq_checker.sv
tb/testbench.sv
